@@ hdl/csem_pkg.sv @@
// Shared types, codes and defaults for the counting semaphore table.
package csem_pkg;

  localparam int CMD_W    = 3;
  localparam int SEM_ID_W = 8;
  localparam int VAL_W    = 32;
  localparam int PID_W    = 16;

  localparam int NUM_SEMS_DEF    = 64;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF    = 16;

  localparam int CMDQ_DEPTH = 2;
  localparam int RESQ_DEPTH = 2;

  localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WAIT    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POST    = 3'd4;

  typedef enum logic [2:0] {
    OP_ERR,
    OP_INIT,
    OP_CHECK,
    OP_DESTROY,
    OP_WAIT,
    OP_POST
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE,
    ST_DRAIN,
    ST_DOUT
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [SEM_ID_W-1:0] sem_id;
    logic [VAL_W-1:0]    init_val;
    logic [PID_W-1:0]    pid;
  } cmd_t;

  typedef struct packed {
    logic             status;
    logic             blocked;
    logic             woken_valid;
    logic [PID_W-1:0] woken_pid;
    logic             last;
  } res_t;

endpackage

@@ hdl/csem_fifo.sv @@
// Small register FIFO used for the command queue and the result queue.
module csem_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

@@ hdl/csem_front.sv @@
// Front end: range-checks and decodes incoming commands into queue entries.
module csem_front #(
  parameter int NUM_SEMS = csem_pkg::NUM_SEMS_DEF,
  parameter int PID_BITS = csem_pkg::PID_BITS_DEF
) (
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [csem_pkg::CMD_W-1:0]     in_cmd,
  input  logic [csem_pkg::SEM_ID_W-1:0]  in_sem_id,
  input  logic [csem_pkg::VAL_W-1:0]     in_initial_value,
  input  logic [csem_pkg::PID_W-1:0]     in_caller_pid,
  output logic                           cq_push,
  output csem_pkg::cmd_t                 cq_wdata,
  input  logic                           cq_full
);

  localparam int IDC_W = csem_pkg::SEM_ID_W + 1;

  logic          id_ok;
  csem_pkg::op_t op;

  assign id_ok   = ({1'b0, in_sem_id} < IDC_W'(NUM_SEMS));
  assign in_full = cq_full;
  assign cq_push = in_push;

  always_comb begin
    unique case (in_cmd)
      csem_pkg::CMD_INIT:    op = csem_pkg::OP_INIT;
      csem_pkg::CMD_CHECK:   op = csem_pkg::OP_CHECK;
      csem_pkg::CMD_DESTROY: op = csem_pkg::OP_DESTROY;
      csem_pkg::CMD_WAIT:    op = csem_pkg::OP_WAIT;
      csem_pkg::CMD_POST:    op = csem_pkg::OP_POST;
      default:               op = csem_pkg::OP_ERR;
    endcase
    if (!id_ok) begin
      op = csem_pkg::OP_ERR;
    end
  end

  always_comb begin
    cq_wdata.op       = op;
    cq_wdata.sem_id   = in_sem_id;
    cq_wdata.init_val = in_initial_value;
    cq_wdata.pid      = csem_pkg::PID_W'(in_caller_pid[PID_BITS-1:0]);
  end

endmodule

@@ hdl/csem_back.sv @@
// Back end: semaphore entry read-modify-write, wait queues and destroy drain.
module csem_back #(
  parameter int NUM_SEMS    = csem_pkg::NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = csem_pkg::PID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cq_empty,
  input  csem_pkg::cmd_t cq_rdata,
  output logic           cq_pop,
  input  logic           rq_full,
  output logic           rq_push,
  output csem_pkg::res_t rq_wdata
);

  localparam int SB    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QB    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FB    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = FB + 1;
  localparam int CNT_W = csem_pkg::VAL_W;
  localparam int ENT_W = CNT_W + QB + FB;
  localparam int WQ_N  = NUM_SEMS * (2 ** QB);

  // entry = {count, head, fill}
  logic [ENT_W-1:0]    ent_mem [NUM_SEMS];
  logic [PID_BITS-1:0] wq_mem  [WQ_N];

  logic [NUM_SEMS-1:0] active_r;
  csem_pkg::state_t    state_r, state_nxt;
  csem_pkg::cmd_t      cur_r, cur_nxt;
  logic                act_r, act_nxt;
  logic [ENT_W-1:0]    ent_q_r;
  logic [PID_BITS-1:0] wq_q_r;
  logic [QB-1:0]       dhead_r, dhead_nxt;
  logic [FB-1:0]       dfill_r, dfill_nxt;

  logic                ent_re, ent_we;
  logic [SB-1:0]       ent_raddr;
  logic [ENT_W-1:0]    ent_wdata;
  logic                wq_re, wq_we;
  logic [QB-1:0]       wq_rslot, wq_wslot;
  logic                act_set, act_clr;

  logic [SB-1:0]       sid, in_sid;
  logic [CNT_W-1:0]    cnt;
  logic [QB-1:0]       head, head_inc, dhead_inc;
  logic [FB-1:0]       fill;
  logic [SUM_W-1:0]    slot_sum;
  logic [QB-1:0]       slot;

  assign sid    = cur_r.sem_id[SB-1:0];
  assign in_sid = cq_rdata.sem_id[SB-1:0];
  assign cnt    = ent_q_r[ENT_W-1 -: CNT_W];
  assign head   = ent_q_r[FB +: QB];
  assign fill   = ent_q_r[FB-1:0];

  assign head_inc  = (head == QB'(QUEUE_DEPTH - 1)) ? '0 : head + QB'(1);
  assign dhead_inc = (dhead_r == QB'(QUEUE_DEPTH - 1)) ? '0 : dhead_r + QB'(1);
  // tail slot = (head + fill) mod depth; sum stays below twice the depth
  assign slot_sum  = SUM_W'(head) + SUM_W'(fill);
  assign slot      = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     QB'(slot_sum - SUM_W'(QUEUE_DEPTH)) : QB'(slot_sum);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    act_nxt   = act_r;
    dhead_nxt = dhead_r;
    dfill_nxt = dfill_r;
    cq_pop    = 1'b0;
    ent_re    = 1'b0;
    ent_raddr = in_sid;
    ent_we    = 1'b0;
    ent_wdata = ent_q_r;
    wq_re     = 1'b0;
    wq_rslot  = head;
    wq_we     = 1'b0;
    wq_wslot  = slot;
    act_set   = 1'b0;
    act_clr   = 1'b0;
    rq_push   = 1'b0;
    rq_wdata  = '0;
    rq_wdata.last = 1'b1;

    unique case (state_r)
      csem_pkg::ST_IDLE: begin
        if (!cq_empty) begin
          cq_pop    = 1'b1;
          cur_nxt   = cq_rdata;
          act_nxt   = 1'b0;
          if (cq_rdata.op != csem_pkg::OP_ERR) begin
            ent_re  = 1'b1;
            act_nxt = active_r[in_sid];
          end
          state_nxt = csem_pkg::ST_EXEC;
        end
      end

      csem_pkg::ST_EXEC: begin
        if (!rq_full) begin
          rq_push   = 1'b1;
          state_nxt = csem_pkg::ST_IDLE;
          if (cur_r.op == csem_pkg::OP_ERR) begin
            rq_wdata.status = 1'b1;
          end else if (cur_r.op == csem_pkg::OP_INIT) begin
            if (act_r) begin
              rq_wdata.status = 1'b1;
            end else begin
              ent_we    = 1'b1;
              ent_wdata = {cur_r.init_val, QB'(0), FB'(0)};
              act_set   = 1'b1;
            end
          end else if (!act_r) begin
            rq_wdata.status = 1'b1;
          end else begin
            case (cur_r.op)
              csem_pkg::OP_WAIT: begin
                if (cnt != '0) begin
                  ent_we    = 1'b1;
                  ent_wdata = {cnt - CNT_W'(1), head, fill};
                end else if (fill >= FB'(QUEUE_DEPTH)) begin
                  rq_wdata.status = 1'b1;
                end else begin
                  wq_we     = 1'b1;
                  ent_we    = 1'b1;
                  ent_wdata = {cnt, head, fill + FB'(1)};
                  rq_wdata.blocked = 1'b1;
                end
              end
              csem_pkg::OP_POST: begin
                ent_we    = 1'b1;
                ent_wdata = {cnt + CNT_W'(1), head, fill};
                if (fill != '0) begin
                  // oldest waiter is read now and reported from the wake state
                  rq_push   = 1'b0;
                  wq_re     = 1'b1;
                  ent_wdata = {cnt + CNT_W'(1), head_inc, fill - FB'(1)};
                  state_nxt = csem_pkg::ST_WAKE;
                end
              end
              csem_pkg::OP_DESTROY: begin
                if (fill == '0) begin
                  act_clr = 1'b1;
                end else begin
                  rq_push   = 1'b0;
                  dhead_nxt = head;
                  dfill_nxt = fill;
                  state_nxt = csem_pkg::ST_DRAIN;
                end
              end
              default: begin
                // check: ok result only
              end
            endcase
          end
        end
      end

      csem_pkg::ST_WAKE: begin
        if (!rq_full) begin
          rq_push              = 1'b1;
          rq_wdata.woken_valid = 1'b1;
          rq_wdata.woken_pid   = csem_pkg::PID_W'(wq_q_r);
          state_nxt            = csem_pkg::ST_IDLE;
        end
      end

      csem_pkg::ST_DRAIN: begin
        wq_re     = 1'b1;
        wq_rslot  = dhead_r;
        dhead_nxt = dhead_inc;
        dfill_nxt = dfill_r - FB'(1);
        state_nxt = csem_pkg::ST_DOUT;
      end

      csem_pkg::ST_DOUT: begin
        if (!rq_full) begin
          rq_push              = 1'b1;
          rq_wdata.woken_valid = 1'b1;
          rq_wdata.woken_pid   = csem_pkg::PID_W'(wq_q_r);
          rq_wdata.last        = (dfill_r == '0);
          if (dfill_r == '0) begin
            act_clr   = 1'b1;
            state_nxt = csem_pkg::ST_IDLE;
          end else begin
            state_nxt = csem_pkg::ST_DRAIN;
          end
        end
      end

      default: state_nxt = csem_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= csem_pkg::ST_IDLE;
      active_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (act_set) begin
        active_r[sid] <= 1'b1;
      end else if (act_clr) begin
        active_r[sid] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    act_r   <= act_nxt;
    dhead_r <= dhead_nxt;
    dfill_r <= dfill_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[sid] <= ent_wdata;
    end
    if (ent_re) begin
      ent_q_r <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wq_we) begin
      wq_mem[{sid, wq_wslot}] <= cur_r.pid[PID_BITS-1:0];
    end
    if (wq_re) begin
      wq_q_r <= wq_mem[{sid, wq_rslot}];
    end
  end

endmodule

@@ hdl/counting_semaphore_table.sv @@
// Counting semaphore table: NUM_SEMS semaphores, each with a 32-bit wrapping count,
// an active flag and a FIFO of up to QUEUE_DEPTH waiting process ids. Commands
// (init, check, destroy, wait, post) enter through a push/full queue interface and
// results leave through an empty/pop queue interface, oldest first, with last set
// on the final result of each command. The engine handles one command at a time:
// it reads the semaphore entry from its memory, then updates it and produces the
// result; a post that wakes a waiter then reports the woken id in a further step,
// and a destroy reads each waiter id from the wait queue memory in its own step
// before reporting it. Short command and result queues let the input side and the
// result side stall independently of the engine. No clearing pass is needed after
// reset.
module counting_semaphore_table #(
  parameter int NUM_SEMS    = csem_pkg::NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = csem_pkg::QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = csem_pkg::PID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [csem_pkg::CMD_W-1:0]    in_cmd,
  input  logic [csem_pkg::SEM_ID_W-1:0] in_sem_id,
  input  logic [csem_pkg::VAL_W-1:0]    in_initial_value,
  input  logic [csem_pkg::PID_W-1:0]    in_caller_pid,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic                          out_status,
  output logic                          out_blocked,
  output logic                          out_woken_valid,
  output logic [csem_pkg::PID_W-1:0]    out_woken_pid,
  output logic                          out_last
);

  localparam int CMD_BITS = $bits(csem_pkg::cmd_t);
  localparam int RES_BITS = $bits(csem_pkg::res_t);

  logic                cq_push, cq_full, cq_pop, cq_empty;
  csem_pkg::cmd_t      cq_wdata, cq_rdata;
  logic [CMD_BITS-1:0] cq_rvec;
  logic                rq_push, rq_full;
  csem_pkg::res_t      rq_wdata, rq_rdata;
  logic [RES_BITS-1:0] rq_rvec;

  csem_front #(
    .NUM_SEMS (NUM_SEMS),
    .PID_BITS (PID_BITS)
  ) u_front (
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cmd           (in_cmd),
    .in_sem_id        (in_sem_id),
    .in_initial_value (in_initial_value),
    .in_caller_pid    (in_caller_pid),
    .cq_push          (cq_push),
    .cq_wdata         (cq_wdata),
    .cq_full          (cq_full)
  );

  csem_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (csem_pkg::CMDQ_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rvec),
    .empty (cq_empty)
  );

  assign cq_rdata = csem_pkg::cmd_t'(cq_rvec);

  csem_back #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_rdata (cq_rdata),
    .cq_pop   (cq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_wdata (rq_wdata)
  );

  csem_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (csem_pkg::RESQ_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rvec),
    .empty (out_empty)
  );

  assign rq_rdata        = csem_pkg::res_t'(rq_rvec);
  assign out_status      = rq_rdata.status;
  assign out_blocked     = rq_rdata.blocked;
  assign out_woken_valid = rq_rdata.woken_valid;
  assign out_woken_pid   = rq_rdata.woken_pid;
  assign out_last        = rq_rdata.last;

endmodule

@@ bench/csem_checker.sv @@
// Checker for the semaphore table: tracks the table state, predicts results, compares them.
module csem_checker
  import csem_pkg::*;
#(
  parameter int NUM_SEMS    = NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [SEM_ID_W-1:0] in_sem_id,
  input  logic [VAL_W-1:0]    in_initial_value,
  input  logic [PID_W-1:0]    in_caller_pid,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic                out_status,
  input  logic                out_blocked,
  input  logic                out_woken_valid,
  input  logic [PID_W-1:0]    out_woken_pid,
  input  logic                out_last,
  output int                  fail_count,
  output int                  pending,
  output int                  cmd_count,
  output int                  result_count,
  output int                  blocked_count,
  output int                  woken_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic             sem_active [NUM_SEMS];
  logic [VAL_W-1:0] sem_count  [NUM_SEMS];
  logic [PID_W-1:0] waiters    [NUM_SEMS][QUEUE_DEPTH];
  int unsigned      wq_head    [NUM_SEMS];
  int unsigned      wq_fill    [NUM_SEMS];
  res_t             sem_results_q [$];

  function automatic res_t make_res(logic st, logic blk, logic wv, logic [PID_W-1:0] pid,
                                    logic lst);
    res_t r;
    r.status      = st;
    r.blocked     = blk;
    r.woken_valid = wv;
    r.woken_pid   = pid;
    r.last        = lst;
    return r;
  endfunction

  // Applies one command to the shadow table and queues the results it should produce.
  task automatic predict_sem_op(input logic [CMD_W-1:0] cmd, input logic [SEM_ID_W-1:0] id,
                                input logic [VAL_W-1:0] val, input logic [PID_W-1:0] pid);
    logic             known_id;
    logic             live;
    logic [PID_W-1:0] who;
    logic [PID_W-1:0] kept_pid;
    int unsigned      slot;
    known_id = id < NUM_SEMS;
    live     = known_id && sem_active[id];
    kept_pid = pid & PID_W'((32'd1 << PID_BITS) - 1);
    if (cmd == CMD_INIT) begin
      if (!known_id || live) begin
        sem_results_q.push_back(make_res(1'b1, 1'b0, 1'b0, '0, 1'b1));
      end else begin
        sem_count[id]  = val;
        wq_head[id]    = 0;
        wq_fill[id]    = 0;
        sem_active[id] = 1'b1;
        sem_results_q.push_back(make_res(1'b0, 1'b0, 1'b0, '0, 1'b1));
      end
    end else if (!live || cmd > CMD_POST) begin
      sem_results_q.push_back(make_res(1'b1, 1'b0, 1'b0, '0, 1'b1));
    end else begin
      case (cmd)
        CMD_CHECK: begin
          sem_results_q.push_back(make_res(1'b0, 1'b0, 1'b0, '0, 1'b1));
        end
        CMD_DESTROY: begin
          if (wq_fill[id] == 0) begin
            sem_results_q.push_back(make_res(1'b0, 1'b0, 1'b0, '0, 1'b1));
          end
          // one transfer per waiter, oldest first
          while (wq_fill[id] != 0) begin
            who         = waiters[id][wq_head[id]];
            wq_head[id] = (wq_head[id] + 1) % QUEUE_DEPTH;
            wq_fill[id] = wq_fill[id] - 1;
            sem_results_q.push_back(make_res(1'b0, 1'b0, 1'b1, who, wq_fill[id] == 0));
          end
          sem_active[id] = 1'b0;
          sem_count[id]  = '0;
          wq_head[id]    = 0;
          wq_fill[id]    = 0;
        end
        CMD_WAIT: begin
          if (sem_count[id] != 0) begin
            sem_count[id] = sem_count[id] - 1'b1;
            sem_results_q.push_back(make_res(1'b0, 1'b0, 1'b0, '0, 1'b1));
          end else if (wq_fill[id] >= QUEUE_DEPTH) begin
            sem_results_q.push_back(make_res(1'b1, 1'b0, 1'b0, '0, 1'b1));
          end else begin
            slot              = (wq_head[id] + wq_fill[id]) % QUEUE_DEPTH;
            waiters[id][slot] = kept_pid;
            wq_fill[id]       = wq_fill[id] + 1;
            sem_results_q.push_back(make_res(1'b0, 1'b1, 1'b0, '0, 1'b1));
          end
        end
        default: begin
          // post: count wraps at 32 bits, oldest waiter is released
          sem_count[id] = sem_count[id] + 1'b1;
          if (wq_fill[id] != 0) begin
            who         = waiters[id][wq_head[id]];
            wq_head[id] = (wq_head[id] + 1) % QUEUE_DEPTH;
            wq_fill[id] = wq_fill[id] - 1;
            sem_results_q.push_back(make_res(1'b0, 1'b0, 1'b1, who, 1'b1));
          end else begin
            sem_results_q.push_back(make_res(1'b0, 1'b0, 1'b0, '0, 1'b1));
          end
        end
      endcase
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (sem_results_q.size() == 0) begin
      $error("result transfer with no expected result pending");
      fail_count++;
    end else begin
      want = sem_results_q.pop_front();
      compare_field("status", 32'(want.status), 32'(out_status));
      compare_field("blocked", 32'(want.blocked), 32'(out_blocked));
      compare_field("woken_valid", 32'(want.woken_valid), 32'(out_woken_valid));
      compare_field("woken_pid", 32'(want.woken_pid), 32'(out_woken_pid));
      compare_field("last", 32'(want.last), 32'(out_last));
    end
    result_count++;
    if (out_blocked === 1'b1) blocked_count++;
    if (out_woken_valid === 1'b1) woken_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        sem_active[i] = 1'b0;
        sem_count[i]  = '0;
        wq_head[i]    = 0;
        wq_fill[i]    = 0;
      end
      sem_results_q.delete();
      fail_count    = 0;
      cmd_count     = 0;
      result_count  = 0;
      blocked_count = 0;
      woken_count   = 0;
    end else begin
      // results first: a command taken at this edge cannot have a result out yet
      if (out_pop && !out_empty) check_result();
      if (in_push && !in_full) begin
        cmd_count++;
        predict_sem_op(in_cmd, in_sem_id, in_initial_value, in_caller_pid);
      end
    end
    pending <= sem_results_q.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the semaphore table bench: clock, reset, command and pop traffic, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csem_pkg::*;

  localparam int NSEM         = NUM_SEMS_DEF;
  localparam int QDEPTH       = QUEUE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 130;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_WAIT   = 40;
  localparam int STALL_LIMIT  = 2000;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                in_push          = 1'b0;
  logic                in_full;
  logic [CMD_W-1:0]    in_cmd           = '0;
  logic [SEM_ID_W-1:0] in_sem_id        = '0;
  logic [VAL_W-1:0]    in_initial_value = '0;
  logic [PID_W-1:0]    in_caller_pid    = '0;
  logic                out_empty;
  logic                out_pop          = 1'b0;
  logic                out_status;
  logic                out_blocked;
  logic                out_woken_valid;
  logic [PID_W-1:0]    out_woken_pid;
  logic                out_last;

  int   fail_count, pending, cmd_count, result_count, blocked_count, woken_count;
  int   items_sent   = 0;
  int   quiet_cycles = 0;
  logic idle_on      = 1'b1;
  logic hold_req     = 1'b0;

  always #5 clk = ~clk;

  counting_semaphore_table u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cmd           (in_cmd),
    .in_sem_id        (in_sem_id),
    .in_initial_value (in_initial_value),
    .in_caller_pid    (in_caller_pid),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_blocked      (out_blocked),
    .out_woken_valid  (out_woken_valid),
    .out_woken_pid    (out_woken_pid),
    .out_last         (out_last)
  );

  csem_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_cmd           (in_cmd),
    .in_sem_id        (in_sem_id),
    .in_initial_value (in_initial_value),
    .in_caller_pid    (in_caller_pid),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_status       (out_status),
    .out_blocked      (out_blocked),
    .out_woken_valid  (out_woken_valid),
    .out_woken_pid    (out_woken_pid),
    .out_last         (out_last),
    .fail_count       (fail_count),
    .pending          (pending),
    .cmd_count        (cmd_count),
    .result_count     (result_count),
    .blocked_count    (blocked_count),
    .woken_count      (woken_count)
  );

  // Offers one command; returns after the edge at which it transfers.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SEM_ID_W-1:0] id,
                          input logic [VAL_W-1:0] val, input logic [PID_W-1:0] pid);
    while (idle_on && $urandom_range(99) < 18) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push          <= 1'b1;
    in_cmd           <= cmd;
    in_sem_id        <= id;
    in_initial_value <= val;
    in_caller_pid    <= pid;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  // Mostly a handful of low ids so commands land on live entries; now and then the top one.
  function automatic logic [SEM_ID_W-1:0] pick_id();
    if ($urandom_range(9) == 0) return SEM_ID_W'(NSEM - 1);
    return SEM_ID_W'($urandom_range(7));
  endfunction

  task automatic run_lifecycle();
    logic [SEM_ID_W-1:0] id;
    logic [VAL_W-1:0]    start;
    int                  r;
    id = pick_id();
    r  = $urandom_range(9);
    if (r == 0) start = '1;
    else if (r == 1) start = $urandom;
    else start = $urandom_range(3);
    send_cmd(CMD_INIT, id, start, PID_W'($urandom));
    repeat ($urandom_range(10, 3)) begin
      r = $urandom_range(9);
      if (r < 6) send_cmd(CMD_WAIT, id, $urandom, PID_W'($urandom));
      else if (r < 9) send_cmd(CMD_POST, id, $urandom, PID_W'($urandom));
      else send_cmd(CMD_CHECK, id, $urandom, PID_W'($urandom));
    end
    if ($urandom_range(3) != 0) send_cmd(CMD_DESTROY, id, $urandom, PID_W'($urandom));
  endtask

  // Fills a wait queue to the brim and at times past it, then tears the entry down.
  task automatic run_queue_fill();
    logic [SEM_ID_W-1:0] id;
    id = pick_id();
    send_cmd(CMD_INIT, id, '0, PID_W'($urandom));
    repeat (QDEPTH + $urandom_range(2)) send_cmd(CMD_WAIT, id, $urandom, PID_W'($urandom));
    if ($urandom_range(1) != 0) send_cmd(CMD_POST, id, $urandom, PID_W'($urandom));
    send_cmd(CMD_DESTROY, id, $urandom, PID_W'($urandom));
  endtask

  initial begin : stimulus
    int directed_items;
    int pick;
    logic hold_done;
    hold_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(CMD_INIT, '0, '0, '0);
    send_cmd(CMD_INIT, '0, $urandom, '0);                    // already active
    send_cmd(CMD_INIT, SEM_ID_W'(NSEM), '1, '1);             // first bad id
    send_cmd(CMD_INIT, '1, '1, '1);                          // highest id
    send_cmd(CMD_CHECK, '0, '0, '0);
    send_cmd(CMD_CHECK, SEM_ID_W'(1), '0, '0);               // never initialized
    send_cmd(CMD_WAIT, '0, '0, '1);                          // count zero: caller blocks
    send_cmd(CMD_POST, '0, '0, '0);                          // wakes that caller
    send_cmd(CMD_INIT, SEM_ID_W'(NSEM - 1), '1, '0);
    send_cmd(CMD_POST, SEM_ID_W'(NSEM - 1), '0, '0);         // count wraps to zero
    send_cmd(CMD_WAIT, SEM_ID_W'(NSEM - 1), '1, '0);
    send_cmd(CMD_DESTROY, SEM_ID_W'(NSEM - 1), '0, '0);      // one waiter released
    for (int c = CMD_POST + 1; c < 2 ** CMD_W; c++) send_cmd(CMD_W'(c), '0, '0, '0);
    send_cmd(CMD_DESTROY, '0, '0, '0);                       // empty queue
    send_cmd(CMD_WAIT, '0, '0, '0);                          // inactive now
    send_cmd(CMD_POST, '0, '0, '0);
    send_cmd(CMD_DESTROY, '0, '0, '0);
    directed_items = items_sent;

    while (items_sent - directed_items < RANDOM_ITEMS) begin
      if (!hold_done && items_sent - directed_items >= 40) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      idle_on = !(items_sent - directed_items >= 70 && items_sent - directed_items < 105);
      pick = $urandom_range(99);
      if (pick < 40) begin
        run_lifecycle();
      end else if (pick < 50) begin
        run_queue_fill();
      end else if (pick < 80) begin
        send_cmd(CMD_W'($urandom_range(CMD_POST)), pick_id(),
                 ($urandom_range(1) != 0) ? VAL_W'($urandom_range(2)) : VAL_W'($urandom),
                 PID_W'($urandom));
      end else begin
        send_cmd(CMD_W'($urandom_range(2 ** CMD_W - 1)), SEM_ID_W'($urandom), $urandom,
                 PID_W'($urandom));
      end
    end
    idle_on = 1'b1;
    in_push <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d commands (%0d directed) and %0d checked result transfers",
             cmd_count, directed_items, result_count);
    $display("%0d waits blocked, %0d waiter ids released by post or destroy",
             blocked_count, woken_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random pops, plus one long hold-off so the block backs up to its input.
  initial begin : receiver
    logic held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_pop <= !(idle_on && $urandom_range(99) < 18);
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $error("no transfer on either side for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

endmodule
